// File: rtl/grid_line_of_sight_check_unit_defines.svh
// grid_line_of_sight_check_unit_defines.svh: assertion macros for the line-of-sight unit
// no dependencies
`ifndef GRID_LINE_OF_SIGHT_CHECK_UNIT_DEFINES_SVH
`define GRID_LINE_OF_SIGHT_CHECK_UNIT_DEFINES_SVH
// implication checked on every clock edge outside reset
`define GLOS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define GLOS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// File: rtl/glos_pkg.sv
// glos_pkg.sv: types, constants and helpers of the line-of-sight unit
// no dependencies
`timescale 1ns / 1ps
package glos_pkg;
	localparam int GRID_COLS_DEF = 16;
	localparam int GRID_ROWS_DEF = 16;
	localparam int COORD_W = 4;
	localparam int CODE_W  = 10;
	// half-unit coordinates: signed, span of +-2*15 plus margin
	localparam int HC_W  = 8;
	localparam int SQ_W  = 20;
	localparam int BIG_W = 44;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef logic signed [HC_W-1:0] hc_t;
	typedef logic signed [SQ_W-1:0] sq_t;
	typedef logic signed [BIG_W-1:0] big_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SETUP, ST_END, ST_SEG, ST_M_VY, ST_M_WX, ST_M_WY, ST_M_DX,
		ST_M_DY, ST_M_X, ST_M_D2, ST_DECIDE, ST_DONE
	} state_t;

	typedef struct packed {
		logic start;
		logic done;
		logic result;
	} ctl_t;

	// blocking test on a cell code: code / 100 by reciprocal multiplication, exact for 10-bit codes
	function automatic logic code_blocks(input logic [CODE_W-1:0] code);
		logic [15:0] recip;
		logic [3:0] q;
		logic [CODE_W-1:0] m;
		recip = 16'(code) * 16'd41;
		q = recip[15:12];
		m = code - CODE_W'(q) * CODE_W'(100);
		code_blocks = (code == CODE_W'(1)) || (code == CODE_W'(2))
			|| (m == CODE_W'(4)) || ((m >= CODE_W'(10)) && (m <= CODE_W'(19)));
	endfunction

	// corner index with max/min projection of offsets (+-1,+-1) on (nx,ny)
	function automatic logic [3:0] extreme(input hc_t nx, input hc_t ny);
		logic [1:0] imax, imin;
		logic signed [HC_W:0] p, hi, lo;
		imax = 2'd0;
		imin = 2'd0;
		hi = '0;
		lo = '0;
		for (int i = 0; i < 4; i++) begin
			p = (i[0] ? {nx[HC_W-1], nx} : -{nx[HC_W-1], nx})
				+ (i[1] ? {ny[HC_W-1], ny} : -{ny[HC_W-1], ny});
			if (i == 0 || p > hi) begin
				imax = 2'(i);
				hi = p;
			end
			if (i == 0 || p < lo) begin
				imin = 2'(i);
				lo = p;
			end
		end
		extreme = {imax, imin};
	endfunction
endpackage

// File: rtl/glos_if.sv
// glos_if.sv: valid/ready channel used for input and result transfers
// depends on nothing
`timescale 1ns / 1ps
interface glos_if #(parameter int W = 1);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/glos_mul.sv
// glos_mul.sv: shared registered multiplier of the line-of-sight unit
// depends on glos_pkg
`timescale 1ns / 1ps
module glos_mul
	import glos_pkg::*;
(
	input  logic clk,
	input  sq_t  a,
	input  sq_t  b,
	output big_t p
);
	logic signed [2*SQ_W-1:0] full;

	assign full = a * b;

	always_ff @(posedge clk) begin
		p <= BIG_W'(full);
	end
endmodule

// File: rtl/glos_seq.sv
// glos_seq.sv: sequencer walking the bounding box with the shared multiplier
// depends on glos_pkg and glos_mul
`timescale 1ns / 1ps
module glos_seq
	import glos_pkg::*;
#(
	parameter int GRID_COLS = GRID_COLS_DEF,
	parameter int GRID_ROWS = GRID_ROWS_DEF,
	localparam int AW = $clog2(GRID_COLS * GRID_ROWS)
)(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [COORD_W-1:0]  x0,
	input  logic [COORD_W-1:0]  y0,
	input  logic [COORD_W-1:0]  x1,
	input  logic [COORD_W-1:0]  y1,
	input  logic                res_room,
	output logic [AW-1:0]       rd_addr,
	output logic                rd_oob,
	input  logic                rd_blocked,
	output ctl_t                ctl
);
	state_t state_q, state_n;
	logic [COORD_W-1:0] x0_q, y0_q, x1_q, y1_q;
	logic [COORD_W-1:0] xmin_q, xmax_q, ymax_q, cx_q, cy_q, xmin_c, ymin_c;
	logic [1:0] smax_q, smin_q, emax_q, emin_q;
	logic seg_q, hit_q, end_bad_q;
	hc_t ax, ay, bx, by, vx, vy, wx, wy, px, py;
	sq_t ma, mb;
	big_t prod, uu;
	big_t vv_q, ww_q, dot_q, wwvv_q;
	logic nearr, hit_n, same_cell;
	logic [3:0] ext;

	assign xmin_c = (x0 < x1) ? x0 : x1;
	assign ymin_c = (y0 < y1) ? y0 : y1;
	assign ext = extreme(hc_t'(-2 * ($signed({1'b0, y1}) - $signed({1'b0, y0}))),
		hc_t'(2 * ($signed({1'b0, x1}) - $signed({1'b0, x0}))));
	assign same_cell = (x0_q == x1_q) && (y0_q == y1_q);

	// segment endpoints for the current edge
	always_comb begin
		logic [1:0] ia, ib;
		ia = seg_q ? smin_q : smax_q;
		ib = seg_q ? emin_q : emax_q;
		ax = hc_t'({x0_q, 1'b0}) + (ia[0] ? hc_t'(2) : hc_t'(0));
		ay = hc_t'({y0_q, 1'b0}) + (ia[1] ? hc_t'(2) : hc_t'(0));
		bx = hc_t'({x1_q, 1'b0}) + (ib[0] ? hc_t'(2) : hc_t'(0));
		by = hc_t'({y1_q, 1'b0}) + (ib[1] ? hc_t'(2) : hc_t'(0));
		px = hc_t'({cx_q, 1'b1});
		py = hc_t'({cy_q, 1'b1});
		vx = bx - ax;
		vy = by - ay;
		wx = px - ax;
		wy = py - ay;
	end

	// operand select for the shared multiplier, one product per step
	always_comb begin
		ma = '0;
		mb = '0;
		unique case (state_q)
			ST_SEG: begin ma = sq_t'(vx); mb = sq_t'(vx); end
			ST_M_VY: begin ma = sq_t'(vy); mb = sq_t'(vy); end
			ST_M_WX: begin ma = sq_t'(wx); mb = sq_t'(wx); end
			ST_M_WY: begin ma = sq_t'(wy); mb = sq_t'(wy); end
			ST_M_DX: begin ma = sq_t'(wx); mb = sq_t'(vx); end
			ST_M_DY: begin ma = sq_t'(wy); mb = sq_t'(vy); end
			ST_M_X: begin ma = sq_t'(ww_q); mb = sq_t'(vv_q); end
			ST_M_D2: begin ma = sq_t'(dot_q); mb = sq_t'(dot_q); end
			default: ;
		endcase
	end

	glos_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(prod));

	// distance decision; prod holds dot^2 here, |w-v|^2 comes from the sums
	always_comb begin
		uu = ww_q - (dot_q <<< 1) + vv_q;
		if (vv_q == big_t'(0) || dot_q <= big_t'(0))
			nearr = ww_q < big_t'(2);
		else if (dot_q >= vv_q)
			nearr = uu < big_t'(2);
		else
			nearr = (wwvv_q - prod) < (vv_q <<< 1);
	end

	assign hit_n = nearr && (rd_blocked || rd_oob);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_n;
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (start) begin
				x0_q <= x0;
				y0_q <= y0;
				x1_q <= x1;
				y1_q <= y1;
				xmin_q <= xmin_c;
				xmax_q <= (x0 > x1) ? x0 : x1;
				ymax_q <= (y0 > y1) ? y0 : y1;
				cx_q <= xmin_c;
				cy_q <= ymin_c;
				{smax_q, smin_q} <= ext;
				{emax_q, emin_q} <= ext;
			end
			ST_SETUP: begin
				seg_q <= 1'b0;
				hit_q <= 1'b0;
			end
			ST_END: end_bad_q <= rd_oob || rd_blocked;
			ST_SEG: ;
			ST_M_VY: vv_q <= prod;
			ST_M_WX: vv_q <= vv_q + prod;
			ST_M_WY: ww_q <= prod;
			ST_M_DX: ww_q <= ww_q + prod;
			ST_M_DY: dot_q <= prod;
			ST_M_X: dot_q <= dot_q + prod;
			ST_M_D2: wwvv_q <= prod;
			ST_DECIDE: begin
				if (hit_n) hit_q <= 1'b1;
				if (!seg_q) seg_q <= 1'b1;
				else begin
					seg_q <= 1'b0;
					if (cx_q == xmax_q) begin
						cx_q <= xmin_q;
						cy_q <= cy_q + 1'b1;
					end else cx_q <= cx_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: if (start) state_n = ST_SETUP;
			ST_SETUP: state_n = ST_END;
			ST_END: state_n = (rd_oob || rd_blocked || same_cell) ? ST_DONE : ST_SEG;
			ST_SEG: state_n = ST_M_VY;
			ST_M_VY: state_n = ST_M_WX;
			ST_M_WX: state_n = ST_M_WY;
			ST_M_WY: state_n = ST_M_DX;
			ST_M_DX: state_n = ST_M_DY;
			ST_M_DY: state_n = ST_M_X;
			ST_M_X: state_n = ST_M_D2;
			ST_M_D2: state_n = ST_DECIDE;
			ST_DECIDE: begin
				if (hit_n || (seg_q && cx_q == xmax_q && cy_q == ymax_q))
					state_n = ST_DONE;
				else state_n = ST_SEG;
			end
			ST_DONE: if (res_room) state_n = ST_IDLE;
			default: state_n = ST_IDLE;
		endcase
	end

	// end cell addressed during setup, box cell otherwise; read data is registered and arrives in the next cycle
	always_comb begin
		logic [COORD_W-1:0] rx, ry;
		rx = (state_q == ST_SETUP || state_q == ST_END) ? x1_q : cx_q;
		ry = (state_q == ST_SETUP || state_q == ST_END) ? y1_q : cy_q;
		rd_oob = (32'(rx) >= GRID_COLS) || (32'(ry) >= GRID_ROWS);
		rd_addr = AW'(32'(ry) * GRID_COLS + 32'(rx));
	end

	assign ctl.start = (state_q == ST_IDLE) && start;
	assign ctl.done = (state_q == ST_DONE) && res_room;
	assign ctl.result = !(end_bad_q || hit_q);
endmodule

// File: rtl/grid_line_of_sight_check_unit.sv
// channel  dir  payload
// in_ch    sink action, from_x, from_y, to_x, to_y, cell_code
// out_ch   src  reachable
// write: no result. query: accept, the setup and end-check states, then for each
// bounding-box cell two segments each walked with the shared multiplier until a hit, and done;
// a query skips the box when the end cell is blocked, off the grid or equals the start.
// the result register frees the input; a finished query waits in done while it is full.
// reset starts a clearing pass over all GRID_COLS*GRID_ROWS cells (256 by default), ready low.
`timescale 1ns / 1ps
`include "grid_line_of_sight_check_unit_defines.svh"
module grid_line_of_sight_check_unit
	import glos_pkg::*;
#(
	parameter int GRID_COLS = GRID_COLS_DEF,
	parameter int GRID_ROWS = GRID_ROWS_DEF
)(
	input logic clk,
	input logic arst_n,
	glos_if.sink in_ch,
	glos_if.source out_ch
);
	localparam int CELLS = GRID_COLS * GRID_ROWS;
	localparam int AW = $clog2(CELLS);
	logic blk_mem [CELLS];
	logic act;
	logic [COORD_W-1:0] fx, fy, tx, ty;
	logic [CODE_W-1:0] code;
	logic [AW-1:0] rd_addr, wr_addr, clr_q;
	logic rd_oob, rd_q, busy_q, ov_q, r_q, clr_busy_q, res_room, wr_en, wr_val;
	ctl_t ctl;

	assign {act, fx, fy, tx, ty, code} = in_ch.data;
	assign in_ch.ready = !busy_q && !clr_busy_q;
	assign res_room = !ov_q || out_ch.ready;

	glos_seq #(.GRID_COLS(GRID_COLS), .GRID_ROWS(GRID_ROWS)) u_seq (
		.clk(clk), .arst_n(arst_n),
		.start(in_ch.valid && in_ch.ready && act == ACT_QUERY),
		.x0(fx), .y0(fy), .x1(tx), .y1(ty), .res_room(res_room),
		.rd_addr(rd_addr), .rd_oob(rd_oob),
		.rd_blocked(rd_q), .ctl(ctl));

	// clearing pass owns the write port until every cell is free
	assign wr_en = clr_busy_q || (in_ch.valid && in_ch.ready && act == ACT_WRITE
		&& 32'(fx) < GRID_COLS && 32'(fy) < GRID_ROWS);
	assign wr_addr = clr_busy_q ? clr_q : AW'(32'(fy) * GRID_COLS + 32'(fx));
	assign wr_val = !clr_busy_q && code_blocks(code);

	always_ff @(posedge clk) begin
		if (wr_en) blk_mem[wr_addr] <= wr_val;
		rd_q <= blk_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ov_q <= 1'b0;
			clr_busy_q <= 1'b1;
			clr_q <= '0;
		end else begin
			if (clr_busy_q) begin
				if (clr_q == AW'(CELLS - 1)) clr_busy_q <= 1'b0;
				else clr_q <= clr_q + 1'b1;
			end
			if (ctl.start) busy_q <= 1'b1;
			if (ctl.done) begin
				busy_q <= 1'b0;
				ov_q <= 1'b1;
			end else if (out_ch.ready) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.done) r_q <= ctl.result;
	end

	assign out_ch.valid = ov_q;
	assign out_ch.data = r_q;

	`GLOS_ASSERT_IMP(a_no_accept_busy, clk, arst_n, busy_q, !in_ch.ready)
	`GLOS_ASSERT_IMP(a_no_accept_clear, clk, arst_n, clr_busy_q, !in_ch.ready)
	`GLOS_ASSERT_NEXT(a_done_gives_valid, clk, arst_n, ctl.done, out_ch.valid)
	`GLOS_ASSERT_IMP(a_done_only_busy, clk, arst_n, ctl.done, busy_q)
endmodule
